/* design/jti_pkg.sv */
// ----------------------------------------------------------------------------
// jti_pkg
// Shared types and constants of the joint trajectory interpolator.
// ----------------------------------------------------------------------------
package jti_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int JOINTS_DEF     = 7;
    localparam logic [19:0] TICK_PERIOD_RESET = 20'd20000;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_MEASURE = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;
    localparam logic [1:0] FUNC_TICK    = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         point_index;
        logic [2:0]         joint_index;
        logic signed [31:0] position;
        logic [31:0]        point_time_us;
        logic [6:0]         point_count;
    } t_in;

    typedef struct packed {
        logic [2:0]         out_joint;
        logic signed [31:0] target_position;
        logic               last;
        logic               finished;
    } t_out;

endpackage

/* design/jti_muldiv.sv */
// ----------------------------------------------------------------------------
// jti_muldiv
// Iterative unsigned a*b/d with the quotient capped at 2^40.
// ----------------------------------------------------------------------------
module jti_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    input  logic [32:0] i_d,
    output logic        o_done,
    output logic [40:0] o_q
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_state;

    t_state      r_state;
    logic [6:0]  r_cnt;
    logic [65:0] r_p;
    logic [32:0] r_a;
    logic [32:0] r_d;
    logic [32:0] r_rem;
    logic [40:0] r_q;
    logic        r_ovf;

    logic [33:0] n_sum;
    logic [33:0] n_rs;
    logic        n_ge;
    logic [40:0] n_q;
    logic        n_ovf;

    // Shift-add step and restoring divide step.
    always_comb begin
        n_sum = {1'b0, r_p[65:33]} + (r_p[0] ? {1'b0, r_a} : 34'd0);
        n_rs  = {r_rem, r_p[65]};
        n_ge  = n_rs >= {1'b0, r_d};
        n_q   = {r_q[39:0], n_ge};
        n_ovf = r_ovf | r_q[40];
    end

    // Sequencer: 33 multiply steps, then 66 divide steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_d     <= i_d;
                        r_p     <= {33'd0, i_b};
                        r_cnt   <= 7'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p   <= {n_sum, r_p[32:1]};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd32) begin
                        r_cnt   <= 7'd0;
                        r_rem   <= 33'd0;
                        r_q     <= 41'd0;
                        r_ovf   <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_p   <= {r_p[64:0], 1'b0};
                    r_rem <= n_ge ? 33'(n_rs - {1'b0, r_d}) : n_rs[32:0];
                    r_q   <= n_q;
                    r_ovf <= n_ovf;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd65) begin
                        // Cap the quotient at 2^40.
                        if (n_ovf || (n_q > {1'b1, 40'd0})) begin
                            o_q <= {1'b1, 40'd0};
                        end else begin
                            o_q <= n_q;
                        end
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/joint_trajectory_interpolator.sv */
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator
// Linear per-joint interpolation along a list of loaded waypoints.
// ----------------------------------------------------------------------------
// Usage: an item transfers at a clock edge with i_start high and o_busy low.
// Load, measured-position and start items leave o_busy low.
// A tick while running raises o_busy and produces one result per joint, each
// shown for one cycle with o_valid; the receiver cannot stall, so results
// must be taken when shown. Each joint whose segment has a nonzero duration
// runs through one shared iterative unit of 33 multiply steps and 66 divide
// steps, after its memory read and setup; a joint whose segment has zero
// duration skips the unit and gives its target waypoint position. A tick
// while not running gives no result. i_cfg_we writes the tick period; the
// user must write it only while the block is idle, and the block itself does
// not enforce this. Synchronous reset clears the pose registers, trajectory
// time and the running flag and sets the period to 20000 us;
// waypoint memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module joint_trajectory_interpolator #(
    parameter int MAX_POINTS = jti_pkg::MAX_POINTS_DEF,
    parameter int JOINTS     = jti_pkg::JOINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  jti_pkg::t_in   i_in,
    output logic           o_busy,
    output logic           o_valid,
    output jti_pkg::t_out  o_out,
    input  logic           i_cfg_we,
    input  logic [19:0]    i_cfg_wdata
);

    localparam int AW  = $clog2(MAX_POINTS * JOINTS);
    localparam int SW  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_TRD, S_TCHK, S_RD, S_SET, S_MD} t_state;

    // Storage.
    logic signed [31:0] r_pos_mem [MAX_POINTS * JOINTS];
    logic [31:0]        r_time_mem [MAX_POINTS];
    logic signed [31:0] r_start_pose [JOINTS];
    logic signed [31:0] r_meas_pose [JOINTS];

    t_state             r_state;
    logic [19:0]        r_period;
    logic [31:0]        r_elapsed;
    logic [31:0]        r_elapsed_nxt;
    logic [SW-1:0]      r_seg;
    logic [PCW-1:0]     r_active;
    logic               r_running;
    logic               r_fin;
    logic               r_adv;
    logic [JW-1:0]      r_j;

    logic signed [31:0] r_pos_cur;
    logic signed [31:0] r_pos_prev;
    logic [31:0]        r_t_cur;
    logic [31:0]        r_t_prev;

    logic signed [32:0] r_base;
    logic               r_neg;

    logic               r_md_start;
    logic [32:0]        r_md_a;
    logic [32:0]        r_md_b;
    logic [32:0]        r_md_d;
    logic               md_done;
    logic [40:0]        md_q;

    // Address and arithmetic helpers.
    logic [AW-1:0]      n_rd_cur;
    logic [AW-1:0]      n_rd_prev;
    logic [AW-1:0]      n_wr_addr;
    logic [SW-1:0]      n_seg_prev;
    logic               n_accept;
    logic               n_load_ok;
    logic               n_joint_ok;
    logic [32:0]        n_sum;
    logic [31:0]        n_el_nxt;
    logic signed [32:0] n_base;
    logic signed [32:0] n_t0;
    logic signed [32:0] n_dur;
    logic signed [32:0] n_off;
    logic signed [32:0] n_diff;
    logic signed [41:0] n_res;
    logic signed [31:0] n_sat;
    logic               n_last;

    always_comb begin
        n_accept   = i_start && !o_busy;
        n_seg_prev = r_seg - SW'(1);
        n_rd_cur   = AW'(r_seg) * AW'(JOINTS) + AW'(r_j);
        n_rd_prev  = AW'(n_seg_prev) * AW'(JOINTS) + AW'(r_j);
        n_wr_addr  = AW'(i_in.point_index) * AW'(JOINTS) + AW'(i_in.joint_index);
        n_joint_ok = 32'(i_in.joint_index) < 32'(JOINTS);
        n_load_ok  = n_joint_ok && (32'(i_in.point_index) < 32'(MAX_POINTS));
        n_sum      = {1'b0, r_elapsed} + {13'd0, r_period};
        n_el_nxt   = n_sum[32] ? 32'hFFFF_FFFF : n_sum[31:0];
        if (r_seg == '0) begin
            n_base = 33'(r_start_pose[r_j]);
            n_t0   = 33'sd0;
        end else begin
            n_base = 33'(r_pos_prev);
            n_t0   = $signed({1'b0, r_t_prev});
        end
        n_dur  = $signed({1'b0, r_t_cur}) - n_t0;
        n_off  = $signed({1'b0, r_elapsed}) - n_t0;
        n_diff = 33'(r_pos_cur) - n_base;
        n_res  = r_neg ? (42'(r_base) - $signed({1'b0, md_q}))
                       : (42'(r_base) + $signed({1'b0, md_q}));
        if (n_res > 42'sd2147483647) begin
            n_sat = 32'sh7FFF_FFFF;
        end else if (n_res < -42'sd2147483648) begin
            n_sat = 32'sh8000_0000;
        end else begin
            n_sat = n_res[31:0];
        end
        n_last = r_j == JW'(JOINTS - 1);
    end

    // Waypoint memories: one write port, two registered read ports each.
    always_ff @(posedge i_clk) begin
        if (n_accept && (i_in.func == jti_pkg::FUNC_LOAD) && n_load_ok) begin
            r_pos_mem[n_wr_addr]        <= i_in.position;
            r_time_mem[SW'(i_in.point_index)] <= i_in.point_time_us;
        end
        r_pos_cur  <= r_pos_mem[n_rd_cur];
        r_pos_prev <= r_pos_mem[n_rd_prev];
        r_t_cur    <= r_time_mem[r_seg];
        r_t_prev   <= r_time_mem[n_seg_prev];
    end

    jti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_md_start),
        .i_a     (r_md_a),
        .i_b     (r_md_b),
        .i_d     (r_md_d),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    // Control sequencer, pose registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_period   <= jti_pkg::TICK_PERIOD_RESET;
            r_elapsed  <= 32'd0;
            r_seg      <= '0;
            r_active   <= '0;
            r_running  <= 1'b0;
            r_j        <= '0;
            r_md_start <= 1'b0;
            o_busy     <= 1'b0;
            o_valid    <= 1'b0;
            for (int i = 0; i < JOINTS; i++) begin
                r_start_pose[i] <= 32'sd0;
                r_meas_pose[i]  <= 32'sd0;
            end
        end else begin
            o_valid    <= 1'b0;
            r_md_start <= 1'b0;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        unique case (i_in.func)
                            jti_pkg::FUNC_LOAD: begin
                            end
                            jti_pkg::FUNC_MEASURE: begin
                                if (n_joint_ok) begin
                                    r_meas_pose[JW'(i_in.joint_index)] <= i_in.position;
                                end
                            end
                            jti_pkg::FUNC_START: begin
                                if (!r_running && (i_in.point_count != 7'd0)) begin
                                    for (int i = 0; i < JOINTS; i++) begin
                                        r_start_pose[i] <= r_meas_pose[i];
                                    end
                                    r_elapsed <= 32'd0;
                                    r_seg     <= '0;
                                    r_running <= 1'b1;
                                    if (32'(i_in.point_count) > 32'(MAX_POINTS)) begin
                                        r_active <= PCW'(MAX_POINTS);
                                    end else begin
                                        r_active <= PCW'(i_in.point_count);
                                    end
                                end
                            end
                            jti_pkg::FUNC_TICK: begin
                                if (r_running) begin
                                    r_j     <= '0;
                                    o_busy  <= 1'b1;
                                    r_state <= S_TRD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TRD: r_state <= S_TCHK;
                S_TCHK: begin
                    // Decide the end-of-tick update before any result goes out.
                    r_elapsed_nxt <= n_el_nxt;
                    r_adv <= n_el_nxt >= r_t_cur;
                    r_fin <= (n_el_nxt >= r_t_cur) && ((PCW'(r_seg) + PCW'(1)) >= r_active);
                    r_state <= S_SET;
                end
                S_RD: r_state <= S_SET;
                S_SET: begin
                    r_base  <= n_base;
                    r_neg   <= ((n_off < 0) != (n_diff < 0)) != (n_dur < 0);
                    r_md_a  <= n_off[32] ? 33'(-n_off) : n_off;
                    r_md_b  <= n_diff[32] ? 33'(-n_diff) : n_diff;
                    r_md_d  <= n_dur[32] ? 33'(-n_dur) : n_dur;
                    if (n_dur == 33'sd0) begin
                        o_out.target_position <= r_pos_cur;
                        o_out.out_joint       <= 3'(r_j);
                        o_out.last            <= n_last;
                        o_out.finished        <= r_fin;
                        o_valid               <= 1'b1;
                        if (n_last) begin
                            r_elapsed <= r_elapsed_nxt;
                            if (r_fin) begin
                                r_running <= 1'b0;
                            end else if (r_adv) begin
                                r_seg <= r_seg + SW'(1);
                            end
                            o_busy  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + JW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_md_start <= 1'b1;
                        r_state    <= S_MD;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        o_out.target_position <= n_sat;
                        o_out.out_joint       <= 3'(r_j);
                        o_out.last            <= n_last;
                        o_out.finished        <= r_fin;
                        o_valid               <= 1'b1;
                        if (n_last) begin
                            r_elapsed <= r_elapsed_nxt;
                            if (r_fin) begin
                                r_running <= 1'b0;
                            end else if (r_adv) begin
                                r_seg <= r_seg + SW'(1);
                            end
                            o_busy  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + JW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
